[hdl/lzss_bitstream_decompress_unit_macros.svh]
// Assertion macros for the LZSS bit-stream decompressor.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef LZSS_BITSTREAM_DECOMPRESS_UNIT_MACROS_SVH
`define LZSS_BITSTREAM_DECOMPRESS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define LBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LBD_ASSERT_IMP(lbl, ante, cons)
`define LBD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/lbd_pkg.sv]
// Shared types and constants for the LZSS bit-stream decompressor.
// No dependencies.
`default_nettype none
package lbd_pkg;

  localparam int WINDOW_BYTES = 4096;
  localparam int SPARE_BYTES  = 256;
  localparam int WIN_DEPTH    = WINDOW_BYTES + SPARE_BYTES;
  localparam int WIN_AW       = $clog2(WIN_DEPTH);
  localparam int MAX_LEN      = 17;
  localparam int LEN_W        = $clog2(MAX_LEN + 1);
  localparam int BUF_BITS     = 24;
  localparam int CNT_W        = $clog2(BUF_BITS + 1);
  localparam int LIT_BITS     = 9;
  localparam int MATCH_BITS   = 17;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    TOK_LIT   = 2'd0,
    TOK_MATCH = 2'd1,
    TOK_END   = 2'd2
  } tok_kind_t;

  // literal: data[7:0]; match: data[15:4] start, data[3:0] length - 2
  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] data;
  } tok_t;

  // window contents after a block restore
  function automatic logic [7:0] init_byte(input logic [WIN_AW-1:0] addr);
    logic [7:0] v;
    if (addr >= WIN_AW'(WINDOW_BYTES)) v = 8'd0;
    else v = 8'(addr >> 4);
    return v;
  endfunction

endpackage
`default_nettype wire

[hdl/lbd_front.sv]
// Front end: takes compressed bytes, keeps the bit buffer and cuts tokens.
// Depends on lbd_pkg and the assertion macro header.
`default_nettype none
`include "lzss_bitstream_decompress_unit_macros.svh"
module lbd_front import lbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output tok_t            tok,
  output logic            tok_valid,
  input  wire logic       tok_ready
);

  logic [BUF_BITS-1:0]            bit_buf;
  logic [CNT_W-1:0]               bit_cnt;
  logic                           last_pend;
  logic                           busy;
  logic [BUF_BITS+MATCH_BITS-1:0] ext;
  logic [MATCH_BITS-1:0]          win17;
  logic                           flag;
  logic                           enough;
  logic [CNT_W-1:0]               need;
  logic [CNT_W-1:0]               bit_cnt_next;

  always_comb begin
    ext    = {bit_buf, MATCH_BITS'(0)} >> bit_cnt;
    win17  = ext[MATCH_BITS-1:0];
    flag   = (bit_cnt != '0) ? win17[MATCH_BITS-1] : 1'b0;
    need   = flag ? CNT_W'(MATCH_BITS) : CNT_W'(LIT_BITS);
    enough = (bit_cnt >= need);
    bit_cnt_next = enough ? (bit_cnt - need) : '0;

    tok.kind = TOK_END;
    tok.data = '0;
    if (bit_cnt != '0) begin
      if (flag) begin
        tok.kind = TOK_MATCH;
        tok.data = win17[15:0];
      end else begin
        tok.kind = TOK_LIT;
        tok.data = {8'd0, win17[15:8]};
      end
    end

    if (bit_cnt != '0) tok_valid = busy && (enough || last_pend);
    else tok_valid = busy && last_pend;
    in_ready = !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf   <= '0;
      bit_cnt   <= '0;
      last_pend <= 1'b0;
      busy      <= 1'b0;
    end else if (in_valid && in_ready) begin
      bit_buf   <= {bit_buf[BUF_BITS-9:0], in_byte};
      bit_cnt   <= bit_cnt + CNT_W'(8);
      last_pend <= last_byte;
      busy      <= 1'b1;
    end else if (busy) begin
      if (tok_valid) begin
        if (tok_ready) begin
          if (bit_cnt == '0) begin
            busy      <= 1'b0;
            last_pend <= 1'b0;
          end else begin
            bit_cnt <= bit_cnt_next;
          end
        end
      end else begin
        busy <= 1'b0;
      end
    end
  end

  `LBD_ASSERT_IMP(a_cnt_max, 1'b1, bit_cnt <= CNT_W'(BUF_BITS))
  `LBD_ASSERT_IMP(a_idle_partial, !busy, bit_cnt < CNT_W'(MATCH_BITS))
  `LBD_ASSERT_IMP(a_idle_no_last, !busy, !last_pend)

endmodule
`default_nettype wire

[hdl/lbd_tok_fifo.sv]
// Short token queue between the front end and the back end.
// Depends on lbd_pkg.
`default_nettype none
module lbd_tok_fifo import lbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  tok_t      wr_tok,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output tok_t      rd_tok,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  tok_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;
  logic               push;
  logic               pop;

  assign wr_ready = (cnt != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_tok   = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/lbd_back.sv]
// Back end: runs tokens against the window memory, holds back one byte, drives results.
// Depends on lbd_pkg and the assertion macro header.
`default_nettype none
`include "lzss_bitstream_decompress_unit_macros.svh"
module lbd_back import lbd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  tok_t       tok,
  input  wire logic  tok_valid,
  output logic       tok_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       block_end,
  output logic       out_valid,
  input  wire logic  out_ready
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t            state;
  logic [7:0]        win [WIN_DEPTH];
  logic [7:0]        cb [MAX_LEN];
  logic [WIN_AW-1:0] wi;
  logic [WIN_AW-1:0] hw;
  logic              held_valid;
  logic [7:0]        held_val;
  logic [11:0]       start;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  rk;
  logic [LEN_W-1:0]  wk;
  logic              rd_pend;
  logic [LEN_W-1:0]  rd_slot;
  logic              rd_old;
  logic [7:0]        rd_init;
  logic [7:0]        mem_q;

  logic              slot_free;
  logic              can_emit;
  logic              emit_go;
  logic [7:0]        emit_b;
  logic              tok_last;
  logic              end_go;
  logic              rd_issue;
  logic [WIN_AW-1:0] rd_addr;
  logic [WIN_AW-1:0] wi_inc;

  always_comb begin
    slot_free = !out_valid || out_ready;
    can_emit  = !held_valid || slot_free;
    emit_go   = 1'b0;
    emit_b    = tok.data[7:0];
    tok_last  = 1'b0;
    end_go    = 1'b0;
    tok_ready = 1'b0;
    rd_issue  = 1'b0;
    rd_addr   = WIN_AW'(start) + WIN_AW'(rk);
    wi_inc    = wi + 1'b1;
    case (state)
      S_IDLE: begin
        if (tok_valid) begin
          case (tok.kind)
            TOK_LIT: begin
              emit_go   = can_emit;
              tok_last  = 1'b1;
              tok_ready = can_emit;
            end
            TOK_MATCH: tok_ready = 1'b1;
            TOK_END: begin
              end_go    = slot_free;
              tok_ready = slot_free;
            end
            default: tok_ready = 1'b1;
          endcase
        end
      end
      S_READ: rd_issue = (rk < len);
      S_WRITE: begin
        emit_go  = can_emit;
        emit_b   = cb[wk];
        tok_last = (wk == len - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_go) win[wi] <= emit_b;
    if (rd_issue) mem_q <= win[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_slot <= rk;
      rd_old  <= (rd_addr < hw);
      rd_init <= init_byte(rd_addr);
    end
    if (rd_pend) cb[rd_slot] <= rd_old ? mem_q : rd_init;
    if (emit_go) held_val <= emit_b;
    if (state == S_IDLE && tok_valid && tok.kind == TOK_MATCH) begin
      start <= tok.data[15:4];
      len   <= LEN_W'(tok.data[3:0]) + LEN_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wi         <= '0;
      hw         <= '0;
      held_valid <= 1'b0;
      rk         <= '0;
      wk         <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      out_byte   <= '0;
      has_byte   <= 1'b0;
      block_end  <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (rd_issue) rk <= rk + 1'b1;

      if (emit_go) begin
        held_valid <= 1'b1;
        if (tok_last && wi_inc >= WIN_AW'(WINDOW_BYTES)) wi <= '0;
        else wi <= wi_inc;
        if (wi_inc > hw) hw <= wi_inc;
      end

      if (end_go) begin
        held_valid <= 1'b0;
        wi         <= '0;
        hw         <= '0;
        out_valid  <= 1'b1;
        out_byte   <= '0;
        has_byte   <= 1'b0;
        block_end  <= 1'b1;
      end else if (emit_go && held_valid) begin
        out_valid <= 1'b1;
        out_byte  <= held_val;
        has_byte  <= 1'b1;
        block_end <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (tok_valid && tok.kind == TOK_MATCH) begin
            rk    <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // last read lands in cb on this edge
          if (rk == len) begin
            wk    <= '0;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (emit_go) begin
            wk <= wk + 1'b1;
            if (tok_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LBD_ASSERT_IMP(a_idle_wrapped, state == S_IDLE, wi < WIN_AW'(WINDOW_BYTES))
  `LBD_ASSERT_IMP(a_fill_covers_wi, 1'b1, hw >= wi)
  `LBD_ASSERT_NEXT(a_end_clears, end_go, !held_valid && wi == '0 && out_valid && block_end)

endmodule
`default_nettype wire

[hdl/lzss_bitstream_decompress_unit.sv]
// Top level of the LZSS bit-stream decompressor: front end, token queue, back end.
// Depends on lbd_pkg, lbd_front, lbd_tok_fifo and lbd_back.
//
// Compressed bytes enter on in_byte/last_byte; decompressed bytes leave on out_byte with
// has_byte set, and each block closes with one item carrying has_byte 0 and block_end 1.
// The block's final decompressed byte is held back and dropped. The front end takes a byte
// only when it is not busy and cuts one token per cycle, while the queue has room, into a
// four-entry queue. The back end handles a literal or an end marker directly; a match of
// L bytes (2 to 17) runs in two phases, set by the single window memory port: all L window
// reads go first, then L writes and results. The window is not rewritten after each
// block: a fill mark tracks the written part.
`default_nettype none
module lzss_bitstream_decompress_unit import lbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            block_end,
  output logic            out_valid,
  input  wire logic       out_ready
);

  tok_t fr_tok;
  logic fr_valid;
  logic fr_ready;
  tok_t bk_tok;
  logic bk_valid;
  logic bk_ready;

  lbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tok       (fr_tok),
    .tok_valid (fr_valid),
    .tok_ready (fr_ready)
  );

  lbd_tok_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_tok   (fr_tok),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .rd_tok   (bk_tok),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready)
  );

  lbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (bk_tok),
    .tok_valid (bk_valid),
    .tok_ready (bk_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .block_end (block_end),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

[tb/lzss_decode_checker.sv]
// Checker for the LZSS bit-stream decompressor: watches both channels, predicts output.
// Depends on lbd_pkg for window sizes; reports mismatch and pending counts to the bench top.
`default_nettype none
module lzss_decode_checker import lbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       has_byte,
  input  wire logic       block_end,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  output int              mismatch_count,
  output int              pending_count
);

  localparam int RESULT_CAP = 34;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } out_item_t;

  out_item_t   pending_out[$];
  logic [7:0]  window [WIN_DEPTH];
  logic [12:0] wr_pos;
  logic [23:0] bit_acc;
  int          bit_avail;
  logic        held_ok;
  logic [7:0]  held_val;
  int          step_items;
  int          fails = 0;

  function automatic void restore_window();
    for (int i = 0; i < WIN_DEPTH; i++) window[i] = (i < WINDOW_BYTES) ? 8'(i >> 4) : 8'd0;
    wr_pos    = '0;
    bit_acc   = '0;
    bit_avail = 0;
    held_ok   = 1'b0;
    held_val  = '0;
  endfunction

  function automatic void put_result(logic [7:0] d, logic h, logic f);
    out_item_t it;
    it.data = d;
    it.has  = h;
    it.fin  = f;
    if (step_items < RESULT_CAP) pending_out = {pending_out, it};
    step_items++;
  endfunction

  // one-byte delay so the last byte of a block can be dropped
  function automatic void emit(logic [7:0] b);
    if (held_ok) put_result(held_val, 1'b1, 1'b0);
    held_val = b;
    held_ok  = 1'b1;
  endfunction

  // next n bits MSB first, zero-padded when short
  function automatic logic [31:0] take_bits(int n);
    logic [31:0] t;
    logic [31:0] m;
    m = (32'd1 << n) - 32'd1;
    if (bit_avail >= n) begin
      t = ({8'd0, bit_acc} >> (bit_avail - n)) & m;
      bit_avail -= n;
    end else begin
      t = ({8'd0, bit_acc} << (n - bit_avail)) & m;
      bit_avail = 0;
    end
    m = (32'd1 << bit_avail) - 32'd1;
    bit_acc = bit_acc & m[23:0];
    return t;
  endfunction

  function automatic void decode_step(logic [7:0] b, logic last);
    logic        flag;
    int          need;
    logic [31:0] tok;
    int          start;
    int          len;
    logic [7:0]  copy [MAX_LEN];
    step_items = 0;
    bit_acc = {bit_acc[15:0], b};
    bit_avail += 8;
    while (bit_avail > 0) begin
      flag = bit_acc[bit_avail-1];
      need = flag ? 17 : 9;
      if (bit_avail < need && !last) break;
      tok = take_bits(need);
      if (!flag) begin
        window[wr_pos] = tok[7:0];
        wr_pos++;
        emit(tok[7:0]);
      end else begin
        start = int'(tok[15:4]);
        len   = int'(tok[3:0]) + 2;
        for (int k = 0; k < len; k++) copy[k] = window[start + k];
        for (int k = 0; k < len; k++) begin
          window[wr_pos] = copy[k];
          wr_pos++;
          emit(copy[k]);
        end
      end
      if (wr_pos >= 13'(WINDOW_BYTES)) wr_pos = '0;
    end
    if (last) begin
      put_result(8'd0, 1'b0, 1'b1);
      restore_window();
    end
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      pending_out.delete();
      restore_window();
    end else begin
      // retire first: a transaction never matches an input taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          $display("%0t: unexpected output transaction: out_byte %02h has_byte %0d block_end %0d",
                   $time, out_byte, has_byte, block_end);
          fails++;
        end else begin
          e = pending_out.pop_front();
          if (out_byte !== e.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.data, out_byte);
            fails++;
          end
          if (has_byte !== e.has) begin
            $display("%0t: has_byte expected %0d actual %0d", $time, e.has, has_byte);
            fails++;
          end
          if (block_end !== e.fin) begin
            $display("%0t: block_end expected %0d actual %0d", $time, e.fin, block_end);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) decode_step(in_byte, last_byte);
    end
    pending_count  <= pending_out.size();
    mismatch_count <= fails;
  end

endmodule
`default_nettype wire

[tb/lzss_bitstream_decompress_unit_tb.sv]
// Bench top for lzss_bitstream_decompress_unit: builds LZSS bit streams, drives the input
// channel with bursts, stalls the output channel, and gives the verdict from lzss_decode_checker.
`default_nettype none
module lzss_bitstream_decompress_unit_tb;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 55;
  localparam int LONG_MATCHES = 8;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] in_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       in_valid = 1'b0;
  logic       out_ready = 1'b0;
  wire logic       in_ready;
  wire logic [7:0] out_byte;
  wire logic       has_byte;
  wire logic       block_end;
  wire logic       out_valid;
  int mismatch_count;
  int pending_count;

  bit       token_bits[$];
  int       burst_left = 0;
  int       bytes_sent = 0;
  int       cycles = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_left = 0;

  lzss_bitstream_decompress_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .block_end (block_end),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  lzss_decode_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .block_end      (block_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lzss_bitstream_decompress_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void add_bit(bit v);
    token_bits = {token_bits, v};
  endfunction

  function automatic void add_lit(logic [7:0] v);
    add_bit(1'b0);
    for (int i = 7; i >= 0; i--) add_bit(v[i]);
  endfunction

  function automatic void add_match(logic [11:0] start, logic [3:0] len_m2);
    add_bit(1'b1);
    for (int i = 11; i >= 0; i--) add_bit(start[i]);
    for (int i = 3; i >= 0; i--) add_bit(len_m2[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  // pads the stream to whole bytes with random bits and sends it as one block
  task automatic send_block();
    logic [7:0] b;
    int nbytes;
    if (token_bits.size() == 0)
      for (int i = 0; i < 8; i++) add_bit(1'($urandom_range(0, 1)));
    while (token_bits.size() % 8 != 0) add_bit(1'($urandom_range(0, 1)));
    nbytes = token_bits.size() / 8;
    for (int i = 0; i < nbytes; i++) begin
      for (int j = 0; j < 8; j++) b = {b[6:0], token_bits.pop_front()};
      send_byte(b, i == nbytes - 1);
    end
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    burst_left = 0;
  endtask

  task automatic send_random_block();
    int ntok;
    ntok = $urandom_range(1, 12);
    repeat (ntok) begin
      if ($urandom_range(0, 1) == 0) add_lit(8'($urandom_range(0, 255)));
      else add_match(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, 63)),
                     4'($urandom_range(0, 15)));
    end
    send_block();
  endtask

  initial begin
    int directed_bytes;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, match into the spare area, overlapping copy, short tokens at block end
    add_lit(8'h00);
    add_lit(8'hff);
    add_lit(8'h5a);
    add_match(12'h000, 4'h0);
    add_match(12'hfff, 4'hf);
    add_match(12'h002, 4'hf);
    add_lit(8'h80);
    send_block();
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b1);
    add_match(12'h0a5, 4'h7);
    add_lit(8'h01);
    send_block();
    directed_bytes = bytes_sent;
    idle_until_drained();

    while (bytes_sent < directed_bytes + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        send_random_block();
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
      end
      if ($urandom_range(0, 19) == 0) idle_until_drained();
    end

    // a block of long matches, some reaching into the spare area, then reads of what they wrote
    for (int i = 0; i < LONG_MATCHES; i++)
      add_match(($urandom_range(0, 9) == 0) ? 12'($urandom_range(4080, 4095))
                                             : 12'($urandom_range(0, 4095)), 4'hf);
    repeat (8) add_lit(8'($urandom_range(0, 255)));
    repeat (4) add_match(12'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    send_block();

    idle_until_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("lzss_bitstream_decompress_unit test passed");
    end else begin
      $display("lzss_bitstream_decompress_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
